FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DGTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define DGTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/dgts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dgts_pkg;

  localparam int IdW  = 5;
  localparam int StW  = 3;
  localparam int ReqW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD_VERTEX = 2'd0,
    REQ_ADD_EDGE   = 2'd1,
    REQ_SORT       = 2'd2
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_CYCLE = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  // Which result the datapath loads into the output register.
  typedef enum logic [2:0] {
    EMIT_NONE   = 3'd0,
    EMIT_NEW    = 3'd1,
    EMIT_FULL   = 3'd2,
    EMIT_RANGE  = 3'd3,
    EMIT_EDGE   = 3'd4,
    EMIT_EMPTY  = 3'd5,
    EMIT_SORTED = 3'd6,
    EMIT_CYCLE  = 3'd7
  } emit_e;

  typedef struct packed {
    logic  latch;
    logic  sort_init;
    logic  scan_step;
    emit_e emit;
  } dgts_cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic            full;
    logic            range_err;
    logic            count_zero;
    logic            eligible;
    logic            last_vertex;
    logic            pass_stall;
    logic            out_free;
  } dgts_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dgts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dgts_req_if;
  import dgts_pkg::*;

  logic            valid;
  logic            ready;
  logic [ReqW-1:0] req_type;
  logic [IdW-1:0]  source_vertex;
  logic [IdW-1:0]  target_vertex;

  modport source (output valid, req_type, source_vertex, target_vertex, input ready);
  modport sink   (input valid, req_type, source_vertex, target_vertex, output ready);
endinterface

interface dgts_res_if;
  import dgts_pkg::*;

  logic           valid;
  logic           ready;
  logic [IdW-1:0] vertex_id;
  logic [StW-1:0] status;
  logic           last_flag;

  modport source (output valid, vertex_id, status, last_flag, input ready);
  modport sink   (input valid, vertex_id, status, last_flag, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dependency_graph_topological_sort_unit.sv
// Directed graph of up to MAX_VERTICES vertices with Kahn-style topological sort.
// One request is in flight at a time; req.ready is high only while the unit is
// idle. Add-vertex and add-edge latch the request and then load their result
// into the output register once it is free. A sort of an empty graph returns
// the empty status; otherwise the sort sets up the working in-degrees and then
// scans one vertex per cycle, holding on a ready vertex while the output is
// full: each pass walks vertices 0..n-1 once, emitting ready vertices and
// releasing their successors in the same cycle, for at most n passes; a pass
// with no progress gives the cycle status. Results leave through a registered
// output; a ready vertex waits while it is full.
`timescale 1ns / 1ps
`default_nettype none

module dependency_graph_topological_sort_unit #(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dgts_req_if.sink   req,
  dgts_res_if.source res
);
  import dgts_pkg::*;

  dgts_cmd_t cmd;
  dgts_sts_t sts;

  dgts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dgts_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req.req_type),
    .source_vertex_i (req.source_vertex),
    .target_vertex_i (req.target_vertex),
    .res_ready_i     (res.ready),
    .res_valid_o     (res.valid),
    .vertex_id_o     (res.vertex_id),
    .status_o        (res.status),
    .last_flag_o     (res.last_flag)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/dgts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dgts_datapath #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dgts_pkg::dgts_cmd_t           cmd_i,
  output dgts_pkg::dgts_sts_t           sts_o,
  input  logic [dgts_pkg::ReqW-1:0]     req_type_i,
  input  logic [dgts_pkg::IdW-1:0]      source_vertex_i,
  input  logic [dgts_pkg::IdW-1:0]      target_vertex_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [dgts_pkg::IdW-1:0]      vertex_id_o,
  output logic [dgts_pkg::StW-1:0]      status_o,
  output logic                          last_flag_o
);
  import dgts_pkg::*;

  localparam int IdxW = $clog2(MAX_VERTICES);
  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VERTICES);

  logic [ReqW-1:0]         req_type_q;
  logic [IdW-1:0]          src_q, dst_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         done_q, done_d;
  logic [IdxW-1:0]         v_q, v_d;
  logic                    progress_q, progress_d;
  logic [MAX_VERTICES-1:0] queued_q, queued_d;
  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_d [MAX_VERTICES];
  logic [CntW-1:0]         indeg_q [MAX_VERTICES];
  logic [CntW-1:0]         indeg_d [MAX_VERTICES];
  logic [CntW-1:0]         work_q [MAX_VERTICES];
  logic [CntW-1:0]         work_d [MAX_VERTICES];
  logic                    out_valid_q, out_valid_d;
  logic [IdW-1:0]          out_id_q, out_id_d;
  logic [StW-1:0]          out_st_q, out_st_d;
  logic                    out_last_q, out_last_d;

  logic [IdW:0]    src_ext, dst_ext, cnt_ext;
  logic [IdxW-1:0] src_idx, dst_idx;
  logic [CntW-1:0] count_m1;
  logic            range_err, dup, eligible, last_vertex, v_last, out_free, emit_sorted;

  assign src_ext     = {1'b0, src_q};
  assign dst_ext     = {1'b0, dst_q};
  assign cnt_ext     = (IdW + 1)'(count_q);
  assign range_err   = (src_ext >= cnt_ext) || (dst_ext >= cnt_ext);
  assign src_idx     = src_q[IdxW-1:0];
  assign dst_idx     = dst_q[IdxW-1:0];
  assign dup         = adj_q[src_idx][dst_idx];
  assign count_m1    = count_q - CntW'(1);
  assign eligible    = !queued_q[v_q] && (work_q[v_q] == '0);
  assign last_vertex = (done_q + CntW'(1)) == count_q;
  assign v_last      = v_q == IdxW'(count_m1);
  assign out_free    = !out_valid_q || res_ready_i;
  assign emit_sorted = cmd_i.emit == EMIT_SORTED;

  always_comb begin
    sts_o.req_type    = req_type_q;
    sts_o.full        = count_q == CntMax;
    sts_o.range_err   = range_err;
    sts_o.count_zero  = count_q == '0;
    sts_o.eligible    = eligible;
    sts_o.last_vertex = last_vertex;
    sts_o.pass_stall  = v_last && !progress_q && !eligible;
    sts_o.out_free    = out_free;
  end

  always_comb begin
    count_d    = count_q;
    done_d     = done_q;
    v_d        = v_q;
    progress_d = progress_q;
    queued_d   = queued_q;
    adj_d      = adj_q;
    indeg_d    = indeg_q;
    work_d     = work_q;

    if (cmd_i.emit == EMIT_NEW) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.emit == EMIT_EDGE && !dup) begin
      adj_d[src_idx][dst_idx] = 1'b1;
      indeg_d[dst_idx]        = indeg_q[dst_idx] + CntW'(1);
    end
    if (cmd_i.sort_init) begin
      work_d     = indeg_q;
      queued_d   = '0;
      done_d     = '0;
      v_d        = '0;
      progress_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (v_last) begin
        v_d        = '0;
        progress_d = 1'b0;
      end else begin
        v_d        = v_q + IdxW'(1);
        progress_d = progress_q || emit_sorted;
      end
    end
    // Emitting a vertex retires it and releases all of its successors at once.
    if (emit_sorted) begin
      queued_d[v_q] = 1'b1;
      done_d        = done_q + CntW'(1);
      for (int t = 0; t < MAX_VERTICES; t++) begin
        if (adj_q[v_q][t] && work_q[t] != '0) begin
          work_d[t] = work_q[t] - CntW'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_id_d    = out_id_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit != EMIT_NONE) begin
      out_valid_d = 1'b1;
      out_id_d    = '0;
      out_last_d  = 1'b1;
      out_st_d    = ST_OK;
      unique case (cmd_i.emit)
        EMIT_NEW:    out_id_d = IdW'(count_q);
        EMIT_FULL:   out_st_d = ST_FULL;
        EMIT_RANGE:  out_st_d = ST_RANGE;
        EMIT_EMPTY:  out_st_d = ST_EMPTY;
        EMIT_CYCLE:  out_st_d = ST_CYCLE;
        EMIT_SORTED: begin
          out_id_d   = IdW'(v_q);
          out_last_d = last_vertex;
        end
        default: out_st_d = ST_OK;
      endcase
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= '0;
      v_q         <= '0;
      progress_q  <= 1'b0;
      queued_q    <= '0;
      adj_q       <= '{default: '0};
      indeg_q     <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      done_q      <= done_d;
      v_q         <= v_d;
      progress_q  <= progress_d;
      queued_q    <= queued_d;
      adj_q       <= adj_d;
      indeg_q     <= indeg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_type_q <= req_type_i;
      src_q      <= source_vertex_i;
      dst_q      <= target_vertex_i;
    end
    work_q     <= work_d;
    out_id_q   <= out_id_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  assign res_valid_o = out_valid_q;
  assign vertex_id_o = out_id_q;
  assign status_o    = out_st_q;
  assign last_flag_o = out_last_q;

  `DGTS_ASSERT(a_queued_matches_done, clk_i, rst_ni, $countones(queued_q) == int'(done_q))
  `DGTS_ASSERT(a_count_bounds, clk_i, rst_ni, done_q <= count_q && count_q <= CntMax)
  `DGTS_ASSERT_IMPLY(a_emit_has_slot, clk_i, rst_ni, cmd_i.emit != EMIT_NONE, out_free)

endmodule

`default_nettype wire

FILE: hw/rtl/dgts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dgts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  dgts_pkg::dgts_sts_t sts_i,
  output dgts_pkg::dgts_cmd_t cmd_o
);
  import dgts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_CYCLE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d         = state_q;
    cmd_o.latch     = 1'b0;
    cmd_o.sort_init = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.emit      = EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.req_type)
          REQ_ADD_VERTEX: begin
            if (sts_i.out_free) begin
              cmd_o.emit = sts_i.full ? EMIT_FULL : EMIT_NEW;
              state_d    = S_IDLE;
            end
          end
          REQ_ADD_EDGE: begin
            if (sts_i.out_free) begin
              cmd_o.emit = sts_i.range_err ? EMIT_RANGE : EMIT_EDGE;
              state_d    = S_IDLE;
            end
          end
          REQ_SORT: begin
            if (sts_i.count_zero) begin
              if (sts_i.out_free) begin
                cmd_o.emit = EMIT_EMPTY;
                state_d    = S_IDLE;
              end
            end else begin
              cmd_o.sort_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        // Hold on a ready vertex until the output register can take it.
        if (!sts_i.eligible || sts_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.eligible) begin
            cmd_o.emit = EMIT_SORTED;
            if (sts_i.last_vertex) begin
              state_d = S_IDLE;
            end
          end else if (sts_i.pass_stall) begin
            state_d = S_CYCLE;
          end
        end
      end
      S_CYCLE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_CYCLE;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DGTS_ASSERT_IMPLY(a_scan_nonempty, clk_i, rst_ni, state_q == S_SCAN, !sts_i.count_zero)

endmodule

`default_nettype wire

FILE: test/graph_order_checker.sv
`timescale 1ns / 1ps

module graph_order_checker #(
  parameter int MAX_V = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dgts_req_if  req,
  dgts_res_if  res,
  output int   err_cnt_o,
  output int   outstanding_o
);
  import dgts_pkg::*;

  typedef struct packed {
    logic [IdW-1:0] vid;
    status_e        st;
    logic           last;
  } graph_result_t;

  logic [5:0]     vertex_total;
  logic [31:0]    succ_rows [32];
  logic [5:0]     pred_count [32];
  graph_result_t  result_q [$];
  int             errs;

  assign err_cnt_o = errs;

  function automatic void expect_result(int vid, status_e st, logic last);
    result_q.push_back('{vid: IdW'(vid), st: st, last: last});
  endfunction

  // Kahn scan: ascending passes, successors released as soon as a vertex leaves.
  function automatic void predict_order();
    logic [5:0]  work [32];
    logic [31:0] taken;
    int          n;
    int          done;
    bit          progress;
    n = (vertex_total > 32) ? 32 : int'(vertex_total);
    if (n == 0) begin
      expect_result(0, ST_EMPTY, 1'b1);
      return;
    end
    for (int v = 0; v < n; v++) work[v] = pred_count[v];
    taken = '0;
    done = 0;
    while (done < n) begin
      progress = 1'b0;
      for (int v = 0; v < n; v++) begin
        if (!taken[v] && work[v] == 0) begin
          taken[v] = 1'b1;
          done++;
          progress = 1'b1;
          expect_result(v, ST_OK, done == n);
          for (int t = 0; t < n; t++) begin
            if (succ_rows[v][t] && work[t] != 0) work[t] = work[t] - 6'd1;
          end
        end
      end
      if (!progress) begin
        expect_result(0, ST_CYCLE, 1'b1);
        break;
      end
    end
  endfunction

  function automatic void predict_request(logic [ReqW-1:0] kind, logic [IdW-1:0] src,
                                          logic [IdW-1:0] dst);
    int lim;
    lim = (MAX_V > 32) ? 32 : MAX_V;
    case (kind)
      REQ_ADD_VERTEX: begin
        if (vertex_total >= lim) begin
          expect_result(0, ST_FULL, 1'b1);
        end else begin
          expect_result(int'(vertex_total), ST_OK, 1'b1);
          vertex_total = vertex_total + 6'd1;
        end
      end
      REQ_ADD_EDGE: begin
        if (src >= vertex_total || dst >= vertex_total) begin
          expect_result(0, ST_RANGE, 1'b1);
        end else begin
          if (!succ_rows[src][dst]) begin
            succ_rows[src][dst] = 1'b1;
            pred_count[dst] = pred_count[dst] + 6'd1;
          end
          expect_result(0, ST_OK, 1'b1);
        end
      end
      REQ_SORT: predict_order();
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    graph_result_t want;
    if (!rst_ni) begin
      vertex_total = '0;
      for (int i = 0; i < 32; i++) begin
        succ_rows[i] = '0;
        pred_count[i] = '0;
      end
      result_q.delete();
      errs = 0;
      outstanding_o <= 0;
    end else begin
      if (req.valid && req.ready)
        predict_request(req.req_type, req.source_vertex, req.target_vertex);
      if (res.valid && res.ready) begin
        if (result_q.size() == 0) begin
          errs++;
          $display("%0t: result with none expected: vertex_id %0d status %0d last_flag %0d",
                   $time, res.vertex_id, res.status, res.last_flag);
        end else begin
          want = result_q.pop_front();
          if (res.vertex_id !== want.vid) begin
            errs++;
            $display("%0t: vertex_id expected %0d actual %0d", $time, want.vid, res.vertex_id);
          end
          if (res.status !== want.st) begin
            errs++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, res.status);
          end
          if (res.last_flag !== want.last) begin
            errs++;
            $display("%0t: last_flag expected %0d actual %0d", $time, want.last, res.last_flag);
          end
        end
      end
      outstanding_o <= result_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dgts_pkg::*;

  localparam int MaxV = 32;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int RandomItems = 460;
  localparam int NoiseItems = 30;
  localparam int QuietLimit = 5000;
  localparam int HoldAfter = 150;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   vtx_made = 0;
  int   quiet = 0;
  int   rank [MaxV];

  dgts_req_if req ();
  dgts_res_if res ();

  dependency_graph_topological_sort_unit #(
    .MAX_VERTICES(MaxV)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .res   (res)
  );

  graph_order_checker #(
    .MAX_V(MaxV)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .res          (res),
    .err_cnt_o    (err_cnt),
    .outstanding_o(outstanding)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stalls plus one long hold-off to back up the request side.
  initial begin
    int seen;
    int hold;
    bit held;
    seen = 0;
    hold = 0;
    held = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res.valid && res.ready) seen++;
      if (seen >= HoldAfter && !held) begin
        held = 1'b1;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(input logic [ReqW-1:0] kind, input int s, input int d);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid         <= 1'b1;
    req.req_type      <= kind;
    req.source_vertex <= IdW'(s);
    req.target_vertex <= IdW'(d);
    do @(posedge clk_i); while (!req.ready);
    if (kind == REQ_ADD_VERTEX && vtx_made < MaxV) vtx_made++;
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_phase(input int idx);
    case ((idx / 40) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  initial begin
    int i;
    int j;
    int t;
    int a;
    int b;
    int pick;
    int lo_v;
    int hi_v;
    req.valid         <= 1'b0;
    req.req_type      <= REQ_ADD_VERTEX;
    req.source_vertex <= '0;
    req.target_vertex <= '0;

    // Hidden rank order keeps the graph acyclic until the loop is closed on purpose.
    for (i = 0; i < MaxV; i++) rank[i] = i;
    for (i = MaxV - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = rank[i];
      rank[i] = rank[j];
      rank[j] = t;
    end
    for (i = 0; i < 2; i++) begin
      for (j = i + 1; j < 3; j++) begin
        if (rank[i] < rank[j]) begin
          t = rank[i];
          rank[i] = rank[j];
          rank[j] = t;
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_req(REQ_SORT, 0, 0);
    send_req(REQ_ADD_EDGE, 0, 0);
    send_req(REQ_ADD_EDGE, 31, 31);
    send_req(REQ_UNUSED, 31, 31);
    send_req(REQ_ADD_VERTEX, 31, 0);
    send_req(REQ_ADD_VERTEX, 0, 31);
    send_req(REQ_ADD_VERTEX, 0, 0);
    send_req(REQ_ADD_EDGE, 2, 1);
    send_req(REQ_ADD_EDGE, 1, 0);
    send_req(REQ_ADD_EDGE, 2, 1);
    send_req(REQ_ADD_EDGE, 3, 0);
    send_req(REQ_ADD_EDGE, 0, 3);
    send_req(REQ_ADD_EDGE, 31, 0);
    send_req(REQ_SORT, 31, 31);
    send_req(REQ_ADD_VERTEX, 0, 0);
    send_req(REQ_ADD_EDGE, 2, 0);
    send_req(REQ_SORT, 0, 0);
    send_req(REQ_UNUSED, 0, 0);
    wait_idle();

    // random acyclic growth with sorts
    for (i = 0; i < RandomItems; i++) begin
      set_phase(i);
      if (i == RandomItems / 2) wait_idle();
      if ($urandom_range(99) < 6)
        send_req(REQ_UNUSED, $urandom_range(31), $urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 10 || vtx_made < 2) begin
        send_req(REQ_ADD_VERTEX, $urandom_range(31), $urandom_range(31));
      end else if (pick < 72) begin
        if (vtx_made < MaxV && $urandom_range(99) < 15) begin
          a = $urandom_range(31, vtx_made);
          b = $urandom_range(31);
          if ($urandom_range(1)) send_req(REQ_ADD_EDGE, a, b);
          else send_req(REQ_ADD_EDGE, b, a);
        end else begin
          a = $urandom_range(vtx_made - 1);
          b = $urandom_range(vtx_made - 2);
          if (b >= a) b++;
          if (rank[a] > rank[b]) begin
            t = a;
            a = b;
            b = t;
          end
          send_req(REQ_ADD_EDGE, a, b);
        end
      end else begin
        send_req(REQ_SORT, $urandom_range(31), $urandom_range(31));
      end
    end
    wait_idle();

    // full graph, then close a loop and a self edge
    set_phase(0);
    while (vtx_made < MaxV) send_req(REQ_ADD_VERTEX, 0, 0);
    send_req(REQ_ADD_VERTEX, 31, 31);
    send_req(REQ_SORT, 0, 0);
    lo_v = 0;
    hi_v = 0;
    for (i = 0; i < MaxV; i++) begin
      if (rank[i] == 0) lo_v = i;
      if (rank[i] == MaxV - 1) hi_v = i;
    end
    send_req(REQ_ADD_EDGE, lo_v, hi_v);
    send_req(REQ_ADD_EDGE, hi_v, lo_v);
    send_req(REQ_SORT, 0, 0);
    send_req(REQ_ADD_EDGE, 31, 31);
    send_req(REQ_SORT, 31, 31);

    // noise on the cyclic graph
    for (i = 0; i < NoiseItems; i++) begin
      set_phase(i * 6);
      pick = $urandom_range(99);
      if (pick < 15) send_req(REQ_ADD_VERTEX, $urandom_range(31), $urandom_range(31));
      else if (pick < 70) send_req(REQ_ADD_EDGE, $urandom_range(31), $urandom_range(31));
      else send_req(REQ_SORT, $urandom_range(31), $urandom_range(31));
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dgts_pkg.sv
hw/rtl/dgts_if.sv
hw/rtl/dgts_datapath.sv
hw/rtl/dgts_ctrl.sv
hw/rtl/dependency_graph_topological_sort_unit.sv
test/graph_order_checker.sv
test/testbench.sv
